// ===== rtl/core/aclat_pkg.sv =====
// shared types, codes and tables for the accented text to latin-1 converter
`default_nettype none
package aclat_pkg;

   typedef enum logic [3:0] {
      MODE_NORMAL  = 4'd0,
      MODE_ACCENT  = 4'd1,
      MODE_GRAVE   = 4'd2,
      MODE_ACUTE   = 4'd3,
      MODE_CIRC    = 4'd4,
      MODE_UML     = 4'd5,
      MODE_CEDIL   = 4'd6,
      MODE_ESCAPE  = 4'd7,
      MODE_CURSOR1 = 4'd8,
      MODE_CURSOR2 = 4'd9
   } mode_type;

   localparam logic [7:0] BYTE_END    = 8'h00;
   localparam logic [7:0] BYTE_ACCENT = 8'h16;
   localparam logic [7:0] BYTE_ESCAPE = 8'h1B;
   localparam logic [7:0] BYTE_CURSOR = 8'h1F;
   localparam logic [7:0] BYTE_SPACE  = 8'h20;
   localparam logic [7:0] BYTE_HASH   = 8'h23;
   localparam logic [7:0] BYTE_QUEST  = 8'h3F;
   localparam logic [7:0] BYTE_BTICK  = 8'h60;
   localparam logic [7:0] BYTE_TILDE  = 8'h7E;
   localparam logic [7:0] BYTE_DEL    = 8'h7F;

   localparam logic [7:0] ACC_GRAVE = 8'h41;
   localparam logic [7:0] ACC_ACUTE = 8'h42;
   localparam logic [7:0] ACC_CIRC  = 8'h43;
   localparam logic [7:0] ACC_UML   = 8'h48;
   localparam logic [7:0] ACC_CEDIL = 8'h4B;

   localparam int unsigned VOWEL_COUNT = 10;
   localparam int unsigned ACCENT_ROWS = 4;

   // rows: grave, acute, circumflex, diaeresis; columns: a e i o u A E I O U
   localparam logic [7:0] VOWEL_MAP [ACCENT_ROWS][VOWEL_COUNT] = '{
      '{8'hE0, 8'hE8, 8'hEC, 8'hF2, 8'hF9, 8'hC0, 8'hC8, 8'hCC, 8'hD2, 8'hD9},
      '{8'hE1, 8'hE9, 8'hED, 8'hF3, 8'hFA, 8'hC1, 8'hC9, 8'hCD, 8'hD3, 8'hDA},
      '{8'hE2, 8'hEA, 8'hEE, 8'hF4, 8'hFB, 8'hC2, 8'hCA, 8'hCE, 8'hD4, 8'hDB},
      '{8'hE4, 8'hEB, 8'hEF, 8'hF6, 8'hFC, 8'hC4, 8'hCB, 8'hCF, 8'hD6, 8'hDC}
   };

   typedef struct packed {
      logic [1:0] count;
      logic [7:0] first;
      logic [7:0] second;
   } result_type;

endpackage
`default_nettype wire

// ===== rtl/core/aclat_if.sv =====
// valid/ready channel interfaces for source bytes and converted bytes
`default_nettype none
interface aclat_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink (input valid, input in_byte, output ready);
endinterface

interface aclat_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_of_run;

   modport source (output valid, output out_byte, output last_of_run, input ready);
   modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/aclat_decode.sv =====
// decode mode register and per-byte translation logic
`default_nettype none
module aclat_decode (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire logic [7:0]            in_byte,
   output aclat_pkg::result_type      result
);
   import aclat_pkg::*;

   mode_type   mode_ff;
   mode_type   mode_in;
   logic       vowel_hit;
   logic [3:0] vowel_idx;
   logic [1:0] accent_row;
   logic [7:0] plain_byte;

   function automatic logic [7:0] plain_char(input logic [7:0] b);
      logic [7:0] r;
      if (b == BYTE_BTICK) begin
         r = 8'hAD;
      end else if (b == BYTE_TILDE) begin
         r = 8'hAF;
      end else if (b == BYTE_DEL) begin
         r = BYTE_SPACE;
      end else if (b < BYTE_SPACE || b[7]) begin
         r = BYTE_QUEST;
      end else begin
         r = b;
      end
      return r;
   endfunction

   always_comb begin
      vowel_hit = 1'b1;
      vowel_idx = 4'd0;
      case (in_byte)
         "a": vowel_idx = 4'd0;
         "e": vowel_idx = 4'd1;
         "i": vowel_idx = 4'd2;
         "o": vowel_idx = 4'd3;
         "u": vowel_idx = 4'd4;
         "A": vowel_idx = 4'd5;
         "E": vowel_idx = 4'd6;
         "I": vowel_idx = 4'd7;
         "O": vowel_idx = 4'd8;
         "U": vowel_idx = 4'd9;
         default: vowel_hit = 1'b0;
      endcase
   end

   assign accent_row = 2'(4'(mode_ff) - 4'(MODE_GRAVE));
   assign plain_byte = plain_char(in_byte);

   always_comb begin
      mode_in = mode_ff;
      result  = '0;
      if (in_byte == BYTE_END) begin
         mode_in = MODE_NORMAL;
      end else begin
         case (mode_ff)
            MODE_ACCENT: begin
               mode_in = MODE_NORMAL;
               case (in_byte)
                  ACC_GRAVE: mode_in = MODE_GRAVE;
                  ACC_ACUTE: mode_in = MODE_ACUTE;
                  ACC_CIRC:  mode_in = MODE_CIRC;
                  ACC_UML:   mode_in = MODE_UML;
                  ACC_CEDIL: mode_in = MODE_CEDIL;
                  "#":  result = '{count: 2'd1, first: 8'hA3, second: 8'h00};
                  "$":  result = '{count: 2'd1, first: 8'h24, second: 8'h00};
                  "&":  result = '{count: 2'd1, first: 8'h23, second: 8'h00};
                  ",":  result = '{count: 2'd2, first: 8'h3C, second: 8'h2D};
                  "-":  result = '{count: 2'd1, first: 8'h5E, second: 8'h00};
                  ".":  result = '{count: 2'd2, first: 8'h2D, second: 8'h3E};
                  "/":  result = '{count: 2'd1, first: 8'h56, second: 8'h00};
                  "0":  result = '{count: 2'd1, first: 8'hB0, second: 8'h00};
                  "1":  result = '{count: 2'd1, first: 8'hB1, second: 8'h00};
                  "8":  result = '{count: 2'd1, first: 8'hF7, second: 8'h00};
                  "<":  result = '{count: 2'd1, first: 8'hBC, second: 8'h00};
                  "=":  result = '{count: 2'd1, first: 8'hBD, second: 8'h00};
                  ">":  result = '{count: 2'd1, first: 8'hBE, second: 8'h00};
                  "j":  result = '{count: 2'd2, first: 8'h4F, second: 8'h45};
                  "z":  result = '{count: 2'd2, first: 8'h6F, second: 8'h65};
                  "{":  result = '{count: 2'd1, first: 8'hDF, second: 8'h00};
                  8'h27: result = '{count: 2'd1, first: 8'hA7, second: 8'h00};
                  default: result = '0;
               endcase
            end
            MODE_GRAVE, MODE_ACUTE, MODE_CIRC, MODE_UML: begin
               mode_in      = MODE_NORMAL;
               result.count = 2'd1;
               result.first = vowel_hit ? VOWEL_MAP[accent_row][vowel_idx] : plain_byte;
            end
            MODE_CEDIL: begin
               mode_in      = MODE_NORMAL;
               result.count = 2'd1;
               if (in_byte == "c") begin
                  result.first = 8'hE7;
               end else if (in_byte == "C") begin
                  result.first = 8'hC7;
               end else begin
                  result.first = plain_byte;
               end
            end
            MODE_ESCAPE: begin
               if (in_byte != BYTE_SPACE && in_byte != BYTE_HASH) begin
                  mode_in = MODE_NORMAL;
               end
            end
            MODE_CURSOR1: mode_in = MODE_CURSOR2;
            MODE_CURSOR2: mode_in = MODE_NORMAL;
            default: begin
               mode_in = MODE_NORMAL;
               if (in_byte == BYTE_ACCENT) begin
                  mode_in = MODE_ACCENT;
               end else if (in_byte == BYTE_ESCAPE) begin
                  mode_in = MODE_ESCAPE;
               end else if (in_byte == BYTE_CURSOR) begin
                  mode_in = MODE_CURSOR1;
               end else begin
                  result.count = 2'd1;
                  result.first = plain_byte;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NORMAL;
      end else if (accept) begin
         mode_ff <= mode_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/aclat_emit.sv =====
// result register holding up to two output bytes, drained one per transfer
`default_nettype none
module aclat_emit (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  load,
   input  wire aclat_pkg::result_type result,
   input  wire logic                  rsp_ready,
   output logic                       rsp_valid,
   output logic [7:0]                 rsp_byte,
   output logic                       rsp_last,
   output logic                       can_accept
);
   import aclat_pkg::*;

   logic [1:0] cnt_ff;
   logic [1:0] cnt_in;
   logic [7:0] first_ff;
   logic [7:0] first_in;
   logic [7:0] second_ff;
   logic [7:0] second_in;
   logic       pop;

   assign rsp_valid  = (cnt_ff != 2'd0);
   assign rsp_byte   = first_ff;
   assign rsp_last   = (cnt_ff == 2'd1);
   assign pop        = rsp_valid && rsp_ready;
   assign can_accept = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp_ready);

   always_comb begin
      cnt_in    = cnt_ff;
      first_in  = first_ff;
      second_in = second_ff;
      if (pop) begin
         if (cnt_ff == 2'd2) begin
            cnt_in   = 2'd1;
            first_in = second_ff;
         end else begin
            cnt_in = 2'd0;
         end
      end
      if (load && result.count != 2'd0) begin
         cnt_in    = result.count;
         first_in  = result.first;
         second_in = result.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      first_ff  <= first_in;
      second_ff <= second_in;
   end

endmodule
`default_nettype wire

// ===== rtl/core/accented_charset_to_latin1.sv =====
// top level: accented home-computer text to iso-8859-1 byte converter
//
// req_if carries one source byte per transfer; rsp_if carries converted bytes,
// with last_of_run set on the final byte caused by one source byte.
// A zero byte, accent prefixes and escape or cursor sequences give no output;
// other control bytes give '?'; a plain or accented character gives one byte;
// four symbol codes give two. A taken byte is on rsp_if from the next cycle.
// One source byte is taken per cycle while the receiver takes every byte;
// a two-byte result holds req_if.ready low while its first byte drains,
// since the single result register holds both bytes.
// req_if.ready stays high when the result register is empty or its last byte
// is being taken, so a new byte enters in the same cycle a result leaves.
// When rsp_if.ready is low, the pending bytes hold and req_if.ready drops.
// Reset (synchronous) returns decoding to normal text mode and empties the
// result register; a zero source byte also returns to normal mode.
`default_nettype none
module accented_charset_to_latin1 (
   input  wire logic   clock,
   input  wire logic   reset,
   aclat_req_if.sink   req_if,
   aclat_rsp_if.source rsp_if
);
   import aclat_pkg::*;

   result_type result;
   logic       accept;
   logic       can_accept;

   assign req_if.ready = can_accept;
   assign accept       = req_if.valid && can_accept;

   aclat_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .in_byte (req_if.in_byte),
      .result  (result)
   );

   aclat_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .result     (result),
      .rsp_ready  (rsp_if.ready),
      .rsp_valid  (rsp_if.valid),
      .rsp_byte   (rsp_if.out_byte),
      .rsp_last   (rsp_if.last_of_run),
      .can_accept (can_accept)
   );

`ifndef ASSERT_OFF
   a_hold_input_on_first_of_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.last_of_run |-> !req_if.ready)
      else $error("source byte taken while a two-byte result is pending");

   a_second_follows_first: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.last_of_run && rsp_if.ready
      |=> rsp_if.valid && rsp_if.last_of_run)
      else $error("second byte of a pair missing after first transfer");

   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_if.valid)
      else $error("result valid right after reset");
`endif

endmodule
`default_nettype wire

// ===== verif/accented_charset_to_latin1_tb.sv =====
// testbench for the accented text to latin-1 converter, checked against a predictor
module accented_charset_to_latin1_tb;
   import aclat_pkg::*;

   localparam int IDLE_LIMIT    = 2000;
   localparam int SETTLE_CYCLES = 8;
   localparam int PRINT_LIMIT   = 50;

   // rows: grave, acute, circumflex, diaeresis; columns: a e i o u A E I O U
   localparam logic [7:0] ACCENTED_LETTER [4][10] = '{
      '{8'hE0, 8'hE8, 8'hEC, 8'hF2, 8'hF9, 8'hC0, 8'hC8, 8'hCC, 8'hD2, 8'hD9},
      '{8'hE1, 8'hE9, 8'hED, 8'hF3, 8'hFA, 8'hC1, 8'hC9, 8'hCD, 8'hD3, 8'hDA},
      '{8'hE2, 8'hEA, 8'hEE, 8'hF4, 8'hFB, 8'hC2, 8'hCA, 8'hCE, 8'hD4, 8'hDB},
      '{8'hE4, 8'hEB, 8'hEF, 8'hF6, 8'hFC, 8'hC4, 8'hCB, 8'hCF, 8'hD6, 8'hDC}
   };

   localparam logic [7:0] KNOWN_ACCENT_CODES [22] = '{
      ACC_GRAVE, ACC_ACUTE, ACC_CIRC, ACC_UML, ACC_CEDIL, "#", "$", "&", ",", "-", ".",
      "/", "0", "1", "8", "<", "=", ">", "j", "z", "{", 8'h27
   };

   localparam logic [7:0] ACCENT_TARGETS [12] = '{
      "a", "e", "i", "o", "u", "A", "E", "I", "O", "U", "c", "C"
   };

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
   } latin1_result_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   int                sender_idle_pct    = 0;
   int                receiver_stall_pct = 0;
   int                error_count        = 0;
   int                quiet_cycles       = 0;
   mode_type          text_mode          = MODE_NORMAL;
   latin1_result_type expected_latin1 [$];

   aclat_req_if req_ch ();
   aclat_rsp_if rsp_ch ();

   accented_charset_to_latin1 dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   always #4 clock = ~clock;

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= PRINT_LIMIT) begin
         $display("mismatch at %0t: %s", $time, what);
      end
   endtask

   function automatic void expect_byte(input logic [7:0] b, input logic last);
      expected_latin1.push_back('{b, last});
   endfunction

   function automatic logic [7:0] plain_latin1(input logic [7:0] b);
      if (b == BYTE_BTICK) return 8'hAD;
      if (b == BYTE_TILDE) return 8'hAF;
      if (b == BYTE_DEL) return BYTE_SPACE;
      if (b < BYTE_SPACE || b[7]) return BYTE_QUEST;
      return b;
   endfunction

   function automatic void predict_latin1(input logic [7:0] b);
      mode_type prior;
      int       slot;
      prior = text_mode;
      slot = -1;
      case (b)
         "a": slot = 0;
         "e": slot = 1;
         "i": slot = 2;
         "o": slot = 3;
         "u": slot = 4;
         "A": slot = 5;
         "E": slot = 6;
         "I": slot = 7;
         "O": slot = 8;
         "U": slot = 9;
         default: slot = -1;
      endcase
      text_mode = MODE_NORMAL;
      if (b == BYTE_END) return;
      case (prior)
         MODE_ACCENT: begin
            case (b)
               ACC_GRAVE: text_mode = MODE_GRAVE;
               ACC_ACUTE: text_mode = MODE_ACUTE;
               ACC_CIRC:  text_mode = MODE_CIRC;
               ACC_UML:   text_mode = MODE_UML;
               ACC_CEDIL: text_mode = MODE_CEDIL;
               "#": expect_byte(8'hA3, 1'b1);
               "$": expect_byte("$", 1'b1);
               "&": expect_byte("#", 1'b1);
               ",": begin
                  expect_byte("<", 1'b0);
                  expect_byte("-", 1'b1);
               end
               "-": expect_byte("^", 1'b1);
               ".": begin
                  expect_byte("-", 1'b0);
                  expect_byte(">", 1'b1);
               end
               "/": expect_byte("V", 1'b1);
               "0": expect_byte(8'hB0, 1'b1);
               "1": expect_byte(8'hB1, 1'b1);
               "8": expect_byte(8'hF7, 1'b1);
               "<": expect_byte(8'hBC, 1'b1);
               "=": expect_byte(8'hBD, 1'b1);
               ">": expect_byte(8'hBE, 1'b1);
               "j": begin
                  expect_byte("O", 1'b0);
                  expect_byte("E", 1'b1);
               end
               "z": begin
                  expect_byte("o", 1'b0);
                  expect_byte("e", 1'b1);
               end
               "{": expect_byte(8'hDF, 1'b1);
               8'h27: expect_byte(8'hA7, 1'b1);
               default: ;
            endcase
         end
         MODE_GRAVE, MODE_ACUTE, MODE_CIRC, MODE_UML: begin
            if (slot >= 0) begin
               expect_byte(ACCENTED_LETTER[prior - MODE_GRAVE][slot], 1'b1);
            end else begin
               expect_byte(plain_latin1(b), 1'b1);
            end
         end
         MODE_CEDIL: begin
            if (b == "c") begin
               expect_byte(8'hE7, 1'b1);
            end else if (b == "C") begin
               expect_byte(8'hC7, 1'b1);
            end else begin
               expect_byte(plain_latin1(b), 1'b1);
            end
         end
         MODE_ESCAPE: begin
            if (b == BYTE_SPACE || b == BYTE_HASH) text_mode = MODE_ESCAPE;
         end
         MODE_CURSOR1: text_mode = MODE_CURSOR2;
         MODE_CURSOR2: ;
         default: begin
            if (b == BYTE_ACCENT) begin
               text_mode = MODE_ACCENT;
            end else if (b == BYTE_ESCAPE) begin
               text_mode = MODE_ESCAPE;
            end else if (b == BYTE_CURSOR) begin
               text_mode = MODE_CURSOR1;
            end else begin
               expect_byte(plain_latin1(b), 1'b1);
            end
         end
      endcase
   endfunction

   // result checking, prediction on each source transfer and the watchdog
   always @(posedge clock) begin : transfer_check
      latin1_result_type want;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_latin1.size() == 0) begin
               report_mismatch($sformatf("unexpected byte %02h", rsp_ch.out_byte));
            end else begin
               want = expected_latin1.pop_front();
               if (rsp_ch.out_byte !== want.out_byte) begin
                  report_mismatch($sformatf("out_byte %02h, want %02h",
                                            rsp_ch.out_byte, want.out_byte));
               end
               if (rsp_ch.last_of_run !== want.last_of_run) begin
                  report_mismatch($sformatf("last_of_run %b, want %b",
                                            rsp_ch.last_of_run, want.last_of_run));
               end
            end
         end
         if (req_ch.valid && req_ch.ready) predict_latin1(req_ch.in_byte);
         if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT) begin
               $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
               $display("Simulation FAILED");
               $finish;
            end
         end
      end
   end

   // receiver side
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   task automatic send_byte(input logic [7:0] b);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < sender_idle_pct) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.in_byte <= b;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic wait_for_drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (expected_latin1.size() != 0) @(posedge clock);
   endtask

   task automatic set_idling(input int sender_pct, input int receiver_pct);
      sender_idle_pct    = sender_pct;
      receiver_stall_pct = receiver_pct;
   endtask

   // mostly well-formed accent, escape and cursor sequences, the rest noise
   task automatic random_stream(input int count);
      int         sent;
      int         kind;
      int         pad;
      logic [7:0] code;
      sent = 0;
      while (sent < count) begin
         kind = $urandom_range(99);
         if (kind < 40) begin
            code = ($urandom_range(99) < 15) ? 8'($urandom_range(255))
                                             : KNOWN_ACCENT_CODES[$urandom_range(21)];
            send_byte(BYTE_ACCENT);
            send_byte(code);
            sent += 2;
            if (code inside {ACC_GRAVE, ACC_ACUTE, ACC_CIRC, ACC_UML, ACC_CEDIL}) begin
               send_byte(($urandom_range(99) < 65) ? ACCENT_TARGETS[$urandom_range(11)]
                                                   : 8'($urandom_range(255)));
               sent++;
            end
         end else if (kind < 55) begin
            pad = $urandom_range(3);
            send_byte(BYTE_ESCAPE);
            repeat (pad) send_byte($urandom_range(1) ? BYTE_SPACE : BYTE_HASH);
            send_byte(8'($urandom_range(255)));
            sent += pad + 2;
         end else if (kind < 65) begin
            send_byte(BYTE_CURSOR);
            send_byte(8'($urandom_range(255)));
            send_byte(8'($urandom_range(255)));
            sent += 3;
         end else if (kind < 69) begin
            send_byte(BYTE_END);
            sent++;
         end else begin
            send_byte(8'($urandom_range(255)));
            sent++;
         end
      end
   endtask

   task automatic test_directed();
      logic [7:0] stream [$];
      stream = '{BYTE_BTICK, BYTE_TILDE, BYTE_DEL, 8'hFF, 8'h01,
                 BYTE_ACCENT, ACC_ACUTE, "e",
                 BYTE_ACCENT, ACC_CEDIL, "C",
                 BYTE_ACCENT, ACC_GRAVE, BYTE_ESCAPE,
                 BYTE_ACCENT, "z",
                 BYTE_ACCENT, "Q",
                 BYTE_ESCAPE, BYTE_SPACE, BYTE_HASH, "x",
                 BYTE_CURSOR, "a", BYTE_END, "b"};
      set_idling(0, 0);
      foreach (stream[i]) send_byte(stream[i]);
   endtask

   task automatic test_back_to_back();
      set_idling(0, 0);
      random_stream(130);
   endtask

   task automatic test_sender_idle();
      set_idling(87, 0);
      random_stream(130);
   endtask

   task automatic test_receiver_stall();
      set_idling(0, 87);
      random_stream(130);
   endtask

   task automatic test_both_idle();
      set_idling(8, 8);
      random_stream(80);
   endtask

   task automatic test_drain_pause();
      set_idling(8, 8);
      random_stream(45);
      wait_for_drain();
      random_stream(45);
   endtask

   initial begin
      req_ch.valid   <= 1'b0;
      req_ch.in_byte <= BYTE_END;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      wait_for_drain();
      test_back_to_back();
      wait_for_drain();
      test_sender_idle();
      wait_for_drain();
      test_receiver_stall();
      wait_for_drain();
      test_both_idle();
      wait_for_drain();
      test_drain_pause();
      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
